@@ hdl/nph_pkg.sv @@
// Shared types, constants and helper functions for the NT password hash core.
package nph_pkg;

   localparam int MAX_CHARS = 128;
   localparam int COUNT_WIDTH = $clog2(MAX_CHARS + 1);
   localparam int RESULT_CHARS = 36;
   localparam int RESULT_WIDTH = $clog2(RESULT_CHARS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = COUNT_WIDTH'(MAX_CHARS);
   localparam logic [RESULT_WIDTH-1:0] LAST_INDEX = RESULT_WIDTH'(RESULT_CHARS - 1);
   localparam logic [RESULT_WIDTH-1:0] THREE_INDEX = RESULT_WIDTH'(1);
   localparam logic [RESULT_WIDTH-1:0] HEX_INDEX = RESULT_WIDTH'(4);
   localparam logic [5:0] STEP_COUNT = 6'd48;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] ROUND2_K = 32'h5a827999;
   localparam logic [31:0] ROUND3_K = 32'h6ed9eba1;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_THREE = 8'h33;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PAD,
      ST_FINAL,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic absorb;        // write the accepted byte into the block
      logic pad;           // place the 0x80 marker and clear the tail
      logic length;        // write the bit length into words 14 and 15
      logic clear_block;   // zero the whole block
      logic round_start;   // load working words from chain
      logic round_step;    // run one MD4 step
      logic round_done;    // fold working words into the chain
      logic restart;       // chain back to initial values
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_round;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
   endfunction

   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] k;
      k = step[3:0];
      if (step < 6'd16) msg_index = k;
      else if (step < 6'd32) msg_index = {k[1:0], k[3:2]};
      else msg_index = {k[0], k[1], k[2], k[3]};
   endfunction

   function automatic logic [4:0] shift_amt(input logic [5:0] step);
      logic [1:0] j;
      j = step[1:0];
      shift_amt = 5'd3;
      if (step < 6'd16) begin
         case (j)
            2'd0: shift_amt = 5'd3;
            2'd1: shift_amt = 5'd7;
            2'd2: shift_amt = 5'd11;
            default: shift_amt = 5'd19;
         endcase
      end else if (step < 6'd32) begin
         case (j)
            2'd0: shift_amt = 5'd3;
            2'd1: shift_amt = 5'd5;
            2'd2: shift_amt = 5'd9;
            default: shift_amt = 5'd13;
         endcase
      end else begin
         case (j)
            2'd0: shift_amt = 5'd3;
            2'd1: shift_amt = 5'd9;
            2'd2: shift_amt = 5'd11;
            default: shift_amt = 5'd15;
         endcase
      end
   endfunction

endpackage

@@ hdl/nph_datapath.sv @@
// Datapath: message block, MD4 step unit, chain words and character counter.
module nph_datapath (
   input  logic               clock,
   input  logic               reset,
   input  nph_pkg::cmd_type   cmd,
   input  logic [7:0]         byte_in,
   input  logic               accept_byte,   // byte counts toward the phrase
   output nph_pkg::status_type status,
   output logic               block_full,    // absorbing this byte fills the block
   output logic               two_blocks,    // padding overflows into a second block
   output logic               count_full,    // character cap reached
   output logic [127:0]       digest
);

   logic [31:0] block_ff [16];
   logic [31:0] block_in [16];
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] work_ff [4];
   logic [31:0] work_in [4];
   logic [5:0] step_ff, step_in;
   logic [nph_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   logic [4:0] pos;
   logic [3:0] wsel;
   logic [31:0] fval, sum, rot, kval;
   logic [4:0] sh;

   assign pos = count_ff[4:0];
   assign wsel = pos[4:1];
   assign block_full = (pos == 5'd31);
   assign two_blocks = (wsel >= 4'd14);
   assign count_full = (count_ff >= nph_pkg::COUNT_LIMIT);
   // all 48 steps done; this cycle folds the chain
   assign status.last_round = (step_ff == nph_pkg::STEP_COUNT);

   // roles rotate each step; the datapath keeps a,b,c,d in fixed slots by shifting
   always_comb begin
      if (step_ff < 6'd16) begin
         fval = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         kval = 32'd0;
      end else if (step_ff < 6'd32) begin
         fval = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
              | (work_ff[2] & work_ff[3]);
         kval = nph_pkg::ROUND2_K;
      end else begin
         fval = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         kval = nph_pkg::ROUND3_K;
      end
      sum = work_ff[0] + fval + block_ff[nph_pkg::msg_index(step_ff)] + kval;
      sh = nph_pkg::shift_amt(step_ff);
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   end

   always_comb begin
      block_in = block_ff;
      chain_in = chain_ff;
      work_in = work_ff;
      step_in = step_ff;
      count_in = count_ff;
      if (cmd.absorb && accept_byte) begin
         if (pos[0]) block_in[wsel] = block_ff[wsel] | {8'd0, byte_in, 16'd0};
         else block_in[wsel] = {24'd0, byte_in};
         count_in = count_ff + 1'b1;
      end
      if (cmd.pad) begin
         if (pos[0]) block_in[wsel] = block_ff[wsel] | 32'h0080_0000;
         else block_in[wsel] = 32'h0000_0080;
         for (int i = 0; i < 16; i++) begin
            if (4'(i) > wsel) block_in[i] = 32'd0;
         end
      end
      if (cmd.clear_block) begin
         for (int i = 0; i < 16; i++) block_in[i] = 32'd0;
      end
      if (cmd.length) begin
         block_in[14] = 32'(count_ff) << 4;
         block_in[15] = 32'd0;
      end
      if (cmd.round_start) begin
         work_in = chain_ff;
         step_in = 6'd0;
      end
      if (cmd.round_step) begin
         // new a goes to the b slot, b and c move on to c and d: next a is old d
         work_in[0] = work_ff[3];
         work_in[1] = rot;
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         step_in = step_ff + 1'b1;
      end
      if (cmd.round_done) begin
         // after 48 steps the slots are back in a,b,c,d order
         for (int i = 0; i < 4; i++) chain_in[i] = chain_ff[i] + work_ff[i];
      end
      if (cmd.restart) begin
         chain_in[0] = nph_pkg::INIT_A;
         chain_in[1] = nph_pkg::INIT_B;
         chain_in[2] = nph_pkg::INIT_C;
         chain_in[3] = nph_pkg::INIT_D;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff <= work_in;
      if (reset) begin
         chain_ff[0] <= nph_pkg::INIT_A;
         chain_ff[1] <= nph_pkg::INIT_B;
         chain_ff[2] <= nph_pkg::INIT_C;
         chain_ff[3] <= nph_pkg::INIT_D;
         count_ff <= '0;
         step_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
         step_ff <= step_in;
      end
   end

   assign digest = {chain_ff[3], chain_ff[2], chain_ff[1], chain_ff[0]};

endmodule

@@ hdl/nph_controller.sv @@
// Controller: sequences absorb, block rounds, padding and result emission.
module nph_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                byte_present,
   input  logic                byte_zero,
   input  logic                end_of_phrase,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [nph_pkg::RESULT_WIDTH-1:0] char_index,
   input  nph_pkg::status_type status,
   input  logic                block_full,
   input  logic                two_blocks,
   input  logic                count_full,
   output nph_pkg::cmd_type    cmd,
   output logic                accept_byte
);

   nph_pkg::state_type state_ff, state_in;
   logic ended_ff, ended_in;
   logic last_ff, last_in;      // the running block is the final one
   logic second_ff, second_in;  // padding needs one more block after this
   logic pend_ff, pend_in;      // phrase end waits behind a full block
   logic [nph_pkg::RESULT_WIDTH-1:0] idx_ff, idx_in;
   logic take;

   assign take = req_tvalid && req_tready;
   assign accept_byte = byte_present && !ended_ff && !byte_zero && !count_full;
   assign char_index = idx_ff;

   always_comb begin
      state_in = state_ff;
      ended_in = ended_ff;
      last_in = last_ff;
      second_in = second_ff;
      pend_in = pend_ff;
      idx_in = idx_ff;
      case (state_ff)
         nph_pkg::ST_IDLE: begin
            if (take) begin
               if (byte_present && byte_zero) ended_in = 1'b1;
               if (accept_byte && block_full) begin
                  state_in = nph_pkg::ST_HASH;
                  last_in = 1'b0;
                  second_in = 1'b0;
                  pend_in = end_of_phrase;
               end else if (end_of_phrase) begin
                  state_in = nph_pkg::ST_PAD;
               end
            end
         end
         nph_pkg::ST_HASH: begin
            if (status.last_round) begin
               if (last_ff) begin
                  state_in = nph_pkg::ST_EMIT;
                  idx_in = '0;
               end else if (second_ff) begin
                  state_in = nph_pkg::ST_FINAL;
               end else if (pend_ff) begin
                  state_in = nph_pkg::ST_PAD;
               end else begin
                  state_in = nph_pkg::ST_IDLE;
               end
            end
         end
         nph_pkg::ST_PAD: begin
            state_in = nph_pkg::ST_HASH;
            pend_in = 1'b0;
            if (two_blocks) begin
               last_in = 1'b0;
               second_in = 1'b1;
            end else begin
               last_in = 1'b1;
               second_in = 1'b0;
            end
         end
         nph_pkg::ST_FINAL: begin
            // length-only block after a spilled pad
            state_in = nph_pkg::ST_HASH;
            last_in = 1'b1;
            second_in = 1'b0;
         end
         nph_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               if (idx_ff == nph_pkg::LAST_INDEX) begin
                  state_in = nph_pkg::ST_IDLE;
                  ended_in = 1'b0;
                  last_in = 1'b0;
                  second_in = 1'b0;
                  pend_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = nph_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         nph_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.absorb = req_tvalid;
            cmd.round_start = req_tvalid;
         end
         nph_pkg::ST_HASH: begin
            cmd.round_step = !status.last_round;
            cmd.round_done = status.last_round;
         end
         nph_pkg::ST_PAD: begin
            cmd.pad = 1'b1;
            cmd.length = !two_blocks;
            cmd.round_start = 1'b1;
         end
         nph_pkg::ST_FINAL: begin
            cmd.clear_block = 1'b1;
            cmd.length = 1'b1;
            cmd.round_start = 1'b1;
         end
         nph_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            cmd.restart = rsp_tready && (idx_ff == nph_pkg::LAST_INDEX);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nph_pkg::ST_IDLE;
         ended_ff <= 1'b0;
         last_ff <= 1'b0;
         second_ff <= 1'b0;
         pend_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ended_ff <= ended_in;
         last_ff <= last_in;
         second_ff <= second_in;
         pend_ff <= pend_in;
         idx_ff <= idx_in;
      end
   end

endmodule

@@ hdl/nph_glue.sv @@
// Response formatter: maps the character index and digest to crypt-string characters.
module nph_glue (
   input  logic [nph_pkg::RESULT_WIDTH-1:0] char_index,
   input  logic [127:0]                     digest,
   output logic [7:0]                       out_char,
   output logic                             final_char
);
   logic [7:0] dbyte;
   logic [3:0] nib;

   // hex digit n (index n+4) shows byte n/2, high nibble first
   always_comb begin
      dbyte = digest[{char_index[4:1] - 4'd2, 3'd0} +: 8];
      nib = char_index[0] ? dbyte[3:0] : dbyte[7:4];
      if (char_index == nph_pkg::THREE_INDEX) out_char = nph_pkg::CHAR_THREE;
      else if (char_index < nph_pkg::HEX_INDEX) out_char = nph_pkg::CHAR_DOLLAR;
      else out_char = nph_pkg::hex_char(nib);
   end

   assign final_char = (char_index == nph_pkg::LAST_INDEX);
endmodule

@@ hdl/nt_password_hash_core.sv @@
// Top level of the NT password hash core: MD4 over UTF-16LE, crypt-form output.
//
// Request beats carry one password byte each: req_tdata[7:0] is the byte,
// req_tuser[0] says a byte is present and req_tlast ends the phrase.
// A zero byte ends the text; bytes past 128 characters are dropped.
// The beat that completes a 32-character block starts 48 MD4 steps, one
// per cycle, then folds the chain; req_tready stays low while the block
// is hashed. After the tlast beat the core pads and hashes one block, or
// two when the padding spills into a second block (one more block when the
// tlast byte itself completes a block), then sends 36 response beats: "$3$$"
// and 32 lowercase hex digits, rsp_tlast on the last, one per cycle while
// rsp_tready is high. A stalled receiver holds the current beat; no request
// is taken until the last beat is accepted. Synchronous reset returns the
// core to idle with the MD4 initial chain and an empty phrase.
module nt_password_hash_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] pass_byte
   input  logic       req_tuser,   // [0] byte_present
   input  logic       req_tlast,   // end_of_phrase
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast    // final_char
);

   nph_pkg::cmd_type cmd;
   nph_pkg::status_type status;
   logic block_full, two_blocks, count_full, accept_byte;
   logic [nph_pkg::RESULT_WIDTH-1:0] idx;
   logic [127:0] digest;

   nph_controller u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .byte_present(req_tuser), .byte_zero(req_tdata == 8'd0),
      .end_of_phrase(req_tlast), .rsp_tready, .rsp_tvalid,
      .char_index(idx), .status, .block_full, .two_blocks, .count_full,
      .cmd, .accept_byte
   );

   nph_datapath u_dp (
      .clock, .reset, .cmd, .byte_in(req_tdata), .accept_byte, .status,
      .block_full, .two_blocks, .count_full, .digest
   );

   nph_glue u_fmt (
      .char_index(idx), .digest, .out_char(rsp_tdata), .final_char(rsp_tlast)
   );

endmodule

@@ hdl/nph_checker.sv @@
// Port-level checker for the NT password hash core, bound to the top level.
module nph_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request taken during response");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
   a_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("response after last beat");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("response out of reset");
endmodule

bind nt_password_hash_core nph_checker u_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking bench for the NT password hash core: MD4 predictor and crypt-string check.
`timescale 1ns / 1ps

module tb_top;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tuser = 1'b0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   nt_password_hash_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [31:0] chain[4];
   logic [31:0] blk[16];
   int unsigned nchars;
   bit          text_done;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } hash_char_type;
   hash_char_type digest_chars[$];

   int errors = 0;
   int beats_in = 0;
   int chars_out = 0;
   int phrases = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   function automatic logic [31:0] rol(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic void md4_compress();
      logic [31:0] v[4];
      logic [31:0] a, b, c, d, f, kk;
      int ia, k, m, s;
      int r2[16] = '{0,4,8,12,1,5,9,13,2,6,10,14,3,7,11,15};
      int r3[16] = '{0,8,4,12,2,10,6,14,1,9,5,13,3,11,7,15};
      int s1[4] = '{3,7,11,19};
      int s2[4] = '{3,5,9,13};
      int s3[4] = '{3,9,11,15};
      for (int i = 0; i < 4; i++) v[i] = chain[i];
      for (int i = 0; i < 48; i++) begin
         ia = (4 - (i & 3)) & 3;
         a = v[ia]; b = v[(ia+1)&3]; c = v[(ia+2)&3]; d = v[(ia+3)&3];
         k = i & 15;
         if (i < 16) begin
            f = (b & c) | (~b & d); m = k; kk = 32'd0; s = s1[i&3];
         end else if (i < 32) begin
            f = (b & c) | (b & d) | (c & d); m = r2[k]; kk = nph_pkg::ROUND2_K;
            s = s2[i&3];
         end else begin
            f = b ^ c ^ d; m = r3[k]; kk = nph_pkg::ROUND3_K; s = s3[i&3];
         end
         v[ia] = rol(a + f + blk[m] + kk, s);
      end
      for (int i = 0; i < 4; i++) chain[i] += v[i];
   endfunction

   function automatic void restart_phrase();
      chain[0] = nph_pkg::INIT_A; chain[1] = nph_pkg::INIT_B;
      chain[2] = nph_pkg::INIT_C; chain[3] = nph_pkg::INIT_D;
      for (int i = 0; i < 16; i++) blk[i] = '0;
      nchars = 0;
      text_done = 0;
   endfunction

   function automatic void put_unit(input logic [31:0] u, input int pos);
      if (pos & 1) blk[pos>>1] |= u << 16;
      else blk[pos>>1] = u;
   endfunction

   function automatic logic [7:0] nib_char(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h57 + {4'd0, n};
   endfunction

   function automatic void predict_beat(input logic [7:0] pb, input bit present,
                                        input bit last);
      int pos;
      logic [7:0] by;
      if (present && !text_done) begin
         if (pb == 8'd0) text_done = 1;
         else if (nchars < nph_pkg::MAX_CHARS) begin
            pos = nchars & 31;
            put_unit({24'd0, pb}, pos);
            nchars++;
            if (pos == 31) md4_compress();
         end
      end
      if (!last) return;
      pos = nchars & 31;
      put_unit(32'h80, pos);
      for (int i = (pos >> 1) + 1; i < 16; i++) blk[i] = '0;
      if ((pos >> 1) >= 14) begin
         md4_compress();
         for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = 32'(nchars * 16);
      blk[15] = 32'd0;
      md4_compress();
      digest_chars.push_back({nph_pkg::CHAR_DOLLAR, 1'b0});
      digest_chars.push_back({nph_pkg::CHAR_THREE, 1'b0});
      digest_chars.push_back({nph_pkg::CHAR_DOLLAR, 1'b0});
      digest_chars.push_back({nph_pkg::CHAR_DOLLAR, 1'b0});
      for (int i = 0; i < 16; i++) begin
         by = 8'(chain[i>>2] >> (8 * (i & 3)));
         digest_chars.push_back({nib_char(by[7:4]), 1'b0});
         digest_chars.push_back({nib_char(by[3:0]), i == 15});
      end
      phrases++;
      restart_phrase();
   endfunction

   // send one beat; sender idles between random bursts
   task automatic send_beat(input logic [7:0] pb, input bit present, input bit last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= pb;
      req_tuser <= present;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_beat(pb, present, last);
      beats_in++;
      @(negedge clock);
   endtask

   task automatic send_text(input int len, input bit end_zero);
      for (int i = 0; i < len; i++) send_beat(8'($urandom_range(1, 255)), 1'b1, 1'b0);
      if (end_zero) send_beat(8'h00, 1'b1, 1'b0);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 7) < 5) || (($urandom_range(0, 3) == 0));
   end

   hash_char_type want;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready || rsp_tvalid && rsp_tready) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 5000) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_out++;
         if (digest_chars.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected char %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = digest_chars.pop_front();
            if (rsp_tdata !== want.ch || rsp_tlast !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display("char %0d: expected %h/%b got %h/%b", chars_out, want.ch,
                           want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   task automatic test_directed();
      send_beat(8'h00, 1'b0, 1'b1);                 // empty phrase
      send_beat(8'hff, 1'b1, 1'b1);                 // single byte at end beat
      send_beat(8'h01, 1'b1, 1'b0); send_beat(8'h80, 1'b1, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0); send_beat(8'h55, 1'b1, 1'b0);  // bytes after zero ignored
      send_beat(8'hfe, 1'b0, 1'b0); send_beat(8'h7f, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b1);                 // zero on end beat
      send_beat(8'h41, 1'b0, 1'b1);                 // no byte on end beat
   endtask

   task automatic test_block_edges();
      // padding spills into a second block; end byte fills a block; cap overflow
      send_text(28, 1'b0); send_beat(8'h00, 1'b0, 1'b1);
      send_text(31, 1'b0); send_beat(8'haa, 1'b1, 1'b1);
      send_text(129, 1'b0); send_beat(8'h5a, 1'b1, 1'b1);
   endtask

   task automatic test_random();
      int n = 0;
      int len;
      while (n < 16) begin
         len = $urandom_range(0, 10);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 15))
               0: send_beat(8'($urandom), 1'b0, 1'b0);
               1: send_beat(8'h00, 1'b1, 1'b0);
               default: send_beat(8'($urandom_range(1, 255)), 1'b1, 1'b0);
            endcase
         end
         send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
         n += len + 1;
      end
   endtask

   initial begin
      restart_phrase();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_block_edges();
      test_random();
      req_tvalid <= 1'b0;
      while (digest_chars.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d request beats over %0d phrases, checked %0d response chars",
               beats_in, phrases, chars_out);
      if (errors == 0) $display("TB_OK");
      else begin
         $display("%0d mismatches", errors);
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
